// File: hw/rtl/nct_pkg.sv
`default_nettype none
package nct_pkg;

	// cube faces, codes 6 and 7 carry no face
	typedef enum logic [2:0] {
		FACE_POS_X = 3'd0,
		FACE_NEG_X = 3'd1,
		FACE_POS_Y = 3'd2,
		FACE_NEG_Y = 3'd3,
		FACE_POS_Z = 3'd4,
		FACE_NEG_Z = 3'd5
	} nct_face_t;

	// control travelling down the cell chain
	typedef struct packed {
		logic vld;
		logic bad;
	} nct_ctl_t;

	localparam int          QBITS         = 7;
	localparam int          SCALE_SQ      = 16129;
	localparam logic [5:0]  FACE_SIZE_RST = 6'd32;
	localparam logic [7:0]  BYTE_MID      = 8'd128;
	localparam logic [7:0]  BYTE_NEG_BASE = 8'd127;

endpackage
`default_nettype wire

// File: hw/rtl/nct_cell.sv
`default_nettype none
module nct_cell #(
	parameter int BIT = 6,
	parameter int SW  = 14,
	parameter int TW  = 26,
	parameter int PW  = 21
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  nct_pkg::nct_ctl_t              ctl_i,
	input  logic [SW-1:0]                  s_i,
	input  logic [2:0]                     neg_i,
	input  logic [2:0][TW-1:0]             r_i,
	input  logic [2:0][PW-1:0]             p_i,
	input  logic [2:0][nct_pkg::QBITS-1:0] q_i,
	output nct_pkg::nct_ctl_t              ctl_o,
	output logic [SW-1:0]                  s_o,
	output logic [2:0]                     neg_o,
	output logic [2:0][TW-1:0]             r_o,
	output logic [2:0][PW-1:0]             p_o,
	output logic [2:0][nct_pkg::QBITS-1:0] q_o
);
	import nct_pkg::*;

	localparam int DW = SW + 16;

	logic [2:0][DW-1:0] delta;
	logic [2:0]         take;

	// growth of q^2*S when this bit is set: 2^(k+1)*q*S + 4^k*S
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			delta[k] = (DW'(p_i[k]) << (BIT + 1)) + (DW'(s_i) << (2 * BIT));
			take[k]  = delta[k] <= DW'(r_i[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else begin
			ctl_o <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		s_o   <= s_i;
		neg_o <= neg_i;
		for (int k = 0; k < 3; k++) begin
			if (take[k]) begin
				r_o[k] <= r_i[k] - TW'(delta[k]);
				p_o[k] <= p_i[k] + PW'(DW'(s_i) << BIT);
				q_o[k] <= q_i[k] | (QBITS'(1) << BIT);
			end else begin
				r_o[k] <= r_i[k];
				p_o[k] <= p_i[k];
				q_o[k] <= q_i[k];
			end
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/normalization_cube_texel_unit.sv
`default_nettype none
// normalisation cube map texel unit
// one texel in per beat: face, col and row are taken when start is high and busy
// is low; busy stays low, so a texel may enter on every clock cycle
// results leave on red, green, blue and bad_item, marked by a one-cycle done
// strobe, in input order; the receiver cannot stall them
// sustained rate is one texel per cycle: three front stages (vector forming,
// squaring, sum of squares and target scaling), seven bit cells, one output stage
// each bit cell decides one bit of the 7-bit quotient magnitude for all three
// components by a restoring square-root style compare, so no divider is needed
// face_size is written through cfg_valid/cfg_ready/cfg_data; ready is always high
// and the new size applies to texels entering after the write beat
// sizes above MAX_FACE_SIZE are clamped; a bad face or a coordinate at or beyond
// the size gives bad_item set and zero bytes
// reset clears the pipeline valid bits and sets face_size to 32; nothing is
// in flight after reset and no clearing pass is needed
module normalization_cube_texel_unit #(
	parameter int MAX_FACE_SIZE = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [5:0] cfg_data,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] face,
	input  logic [4:0] col,
	input  logic [4:0] row,
	output logic       done,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output logic       bad_item
);
	import nct_pkg::*;

	localparam int NW = $clog2(MAX_FACE_SIZE + 1);
	localparam int CW = NW + 2;
	localparam int SW = 2 * NW + 2;
	localparam int TW = 2 * NW + 14;
	localparam int PW = SW + 7;

	// configuration register
	logic [5:0] face_size_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_size_q <= FACE_SIZE_RST;
		end else if (cfg_valid && cfg_ready) begin
			face_size_q <= cfg_data;
		end
	end

	// stage 1: signed vector from face, a and b
	logic [NW-1:0]        n;
	logic signed [CW-1:0] av, bv, nv;
	logic signed [CW-1:0] cv [3];
	logic                 bad_face, bad_in;

	always_comb begin
		if (int'(face_size_q) > MAX_FACE_SIZE) begin
			n = NW'(MAX_FACE_SIZE);
		end else begin
			n = NW'(face_size_q);
		end
		nv = signed'(CW'(n));
		av = signed'(CW'({col, 1'b1})) - nv;
		bv = signed'(CW'({row, 1'b1})) - nv;
		bad_face = 1'b0;
		case (face)
			FACE_POS_X: begin
				cv[0] = nv;  cv[1] = -bv; cv[2] = -av;
			end
			FACE_NEG_X: begin
				cv[0] = -nv; cv[1] = -bv; cv[2] = av;
			end
			FACE_POS_Y: begin
				cv[0] = av;  cv[1] = nv;  cv[2] = bv;
			end
			FACE_NEG_Y: begin
				cv[0] = av;  cv[1] = -nv; cv[2] = -bv;
			end
			FACE_POS_Z: begin
				cv[0] = av;  cv[1] = -bv; cv[2] = nv;
			end
			FACE_NEG_Z: begin
				cv[0] = -av; cv[1] = -bv; cv[2] = -nv;
			end
			default: begin
				cv[0] = '0;  cv[1] = '0;  cv[2] = '0;
				bad_face = 1'b1;
			end
		endcase
		bad_in = bad_face || (int'(col) >= int'(n)) || (int'(row) >= int'(n));
	end

	nct_ctl_t            ctl_s1, ctl_s2, ctl_s3;
	logic [2:0]          neg_s1, neg_s2, neg_s3;
	logic [2:0][NW-1:0]  mag_s1;
	logic [2:0][2*NW-1:0] sq_s2;
	logic [SW-1:0]       s_s3;
	logic [2:0][TW-1:0]  t_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s1 <= '{vld: start && !busy, bad: bad_in};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			neg_s1[k] <= cv[k][CW-1];
			mag_s1[k] <= cv[k][CW-1] ? NW'(-cv[k]) : NW'(cv[k]);
		end
		// stage 2: squares of the component magnitudes
		neg_s2 <= neg_s1;
		for (int k = 0; k < 3; k++) begin
			sq_s2[k] <= mag_s1[k] * mag_s1[k];
		end
		// stage 3: S and target (127*c)^2, less one for negative parts
		neg_s3 <= neg_s2;
		s_s3   <= SW'(sq_s2[0]) + SW'(sq_s2[1]) + SW'(sq_s2[2]);
		for (int k = 0; k < 3; k++) begin
			t_s3[k] <= TW'(TW'(sq_s2[k]) * TW'(SCALE_SQ)) - TW'(neg_s2[k]);
		end
	end

	// bit cells, most significant quotient bit first
	nct_ctl_t                  ctl_ch [QBITS+1];
	logic [SW-1:0]             s_ch   [QBITS+1];
	logic [2:0]                neg_ch [QBITS+1];
	logic [2:0][TW-1:0]        r_ch   [QBITS+1];
	logic [2:0][PW-1:0]        p_ch   [QBITS+1];
	logic [2:0][QBITS-1:0]     q_ch   [QBITS+1];

	assign ctl_ch[0] = ctl_s3;
	assign s_ch[0]   = s_s3;
	assign neg_ch[0] = neg_s3;
	assign r_ch[0]   = t_s3;
	assign p_ch[0]   = '0;
	assign q_ch[0]   = '0;

	for (genvar j = 0; j < QBITS; j++) begin : g_cell
		nct_cell #(
			.BIT (QBITS - 1 - j),
			.SW  (SW),
			.TW  (TW),
			.PW  (PW)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl_i  (ctl_ch[j]),
			.s_i    (s_ch[j]),
			.neg_i  (neg_ch[j]),
			.r_i    (r_ch[j]),
			.p_i    (p_ch[j]),
			.q_i    (q_ch[j]),
			.ctl_o  (ctl_ch[j+1]),
			.s_o    (s_ch[j+1]),
			.neg_o  (neg_ch[j+1]),
			.r_o    (r_ch[j+1]),
			.p_o    (p_ch[j+1]),
			.q_o    (q_ch[j+1])
		);
	end

	// output stage: positive part 128+q, negative part 128-(q+1)
	logic [2:0][7:0] byte_d;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (ctl_ch[QBITS].bad) begin
				byte_d[k] = '0;
			end else if (neg_ch[QBITS][k]) begin
				byte_d[k] = BYTE_NEG_BASE - {1'b0, q_ch[QBITS][k]};
			end else begin
				byte_d[k] = BYTE_MID + {1'b0, q_ch[QBITS][k]};
			end
		end
	end

	logic       done_q;
	logic [7:0] red_q, green_q, blue_q;
	logic       bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_ch[QBITS].vld;
		end
	end

	always_ff @(posedge clk) begin
		red_q   <= byte_d[0];
		green_q <= byte_d[1];
		blue_q  <= byte_d[2];
		bad_q   <= ctl_ch[QBITS].bad;
	end

	assign done     = done_q;
	assign red      = red_q;
	assign green    = green_q;
	assign blue     = blue_q;
	assign bad_item = bad_q;

endmodule
`default_nettype wire
